### rtl/core/roi_mean_depth_estimator_macros.svh
// assertion macros shared by the roi mean depth blocks
// each one samples on clk and is disabled while rst_n is low
`ifndef ROI_MEAN_DEPTH_ESTIMATOR_MACROS_SVH
`define ROI_MEAN_DEPTH_ESTIMATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RMDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RMDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMDE_ASSERT_IMPL(lbl, ante, cons, msg)
`define RMDE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/rmde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmde_pkg;

  // frame geometry
  localparam int IMAGE_WIDTH = 1920;
  localparam int MAX_HEIGHT  = 2048;
  localparam int COL_W       = $clog2(IMAGE_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
  localparam int COL_START   = IMAGE_WIDTH * 3 / 10;
  localparam int COL_END     = IMAGE_WIDTH * 7 / 10;

  // configuration
  localparam int CFG_W          = 12;
  localparam int HEIGHT_DEFAULT = 1200;

  // field and counter widths
  localparam int DEPTH_W = 32;
  localparam int MEAN_W  = 17;
  localparam int KEPT_W  = 20;
  localparam int TOTAL_W = 22;
  localparam int SUM_W   = 36;
  localparam int EXP_W   = $clog2(IMAGE_WIDTH * (2 ** CFG_W));

  // float32 decode and millimetre scaling
  localparam int EXPO_LO  = 120;
  localparam int EXPO_HI  = 129;
  localparam int EXPO_REF = 150;
  localparam int MM_Q4    = 16000;

  // divide by ten through a reciprocal, exact for operands below 2^18
  localparam int DIV10_MUL = 52429;
  localparam int DIV10_SH  = 19;

  // queue between front and back
  localparam int Q_DEPTH = 2;

  // one finished frame as handed to the back end
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [KEPT_W-1:0] count;
    logic              err;
  } rmde_rec_t;

endpackage
`default_nettype wire

### rtl/core/rmde_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "roi_mean_depth_estimator_macros.svh"
module rmde_queue import rmde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rmde_rec_t push_rec,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output rmde_rec_t pop_rec
);

  localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  rmde_rec_t           mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full      = (count_r == QCNT_W'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_rec   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `RMDE_ASSERT_IMPL(a_no_push_full, push, !full, "push into a full queue")
  `RMDE_ASSERT_IMPL(a_no_pop_empty, pop, pop_valid, "pop from an empty queue")
  `RMDE_ASSERT_NEXT(a_fill_bound, push && !pop, count_r != '0,
                    "queue fill level lost a push")

endmodule
`default_nettype wire

### rtl/core/rmde_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rmde_front import rmde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DEPTH_W-1:0] in_depth_bits,
  input  logic               in_frame_end,
  output logic               push,
  output rmde_rec_t          push_rec,
  input  logic               q_full
);

  localparam int HS_W = ROW_W + 3;
  localparam int MP_W = HS_W + 17;

  function automatic logic [ROW_W-1:0] div10(input logic [HS_W-1:0] x);
    logic [MP_W-1:0] p;
    p = MP_W'(x) * MP_W'(DIV10_MUL);
    return ROW_W'(p >> DIV10_SH);
  endfunction

  logic [CFG_W-1:0]   frame_height_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [TOTAL_W-1:0] total_r;
  logic [SUM_W-1:0]   sum_r;
  logic [KEPT_W-1:0]  cnt_r;

  logic               s1_valid_r;
  logic [DEPTH_W-1:0] s1_bits_r;
  logic               s1_win_r;
  logic               s1_last_r;
  logic               s1_err_r;

  logic               s2_valid_r;
  logic               s2_keep_r;
  logic [MEAN_W-1:0]  s2_q4_r;
  logic               s2_last_r;
  logic               s2_err_r;

  logic               hold;
  logic               accept;
  logic [ROW_W-1:0]   h_clamp;
  logic [ROW_W-1:0]   row_start;
  logic [ROW_W-1:0]   row_end;
  logic               win;
  logic [TOTAL_W-1:0] total_inc;
  logic               err;

  // the whole front pipeline holds while a frame end waits for queue space
  assign hold     = s2_valid_r && s2_last_r && q_full;
  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // window rows from the clamped height
  assign h_clamp   = (32'(frame_height_r) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT)
                                                         : ROW_W'(frame_height_r);
  assign row_start = div10(HS_W'(h_clamp) * HS_W'(3));
  assign row_end   = div10(HS_W'(h_clamp) * HS_W'(7));

  assign win = (col_r >= COL_W'(COL_START)) && (col_r < COL_W'(COL_END)) &&
               (row_r >= row_start) && (row_r < row_end);

  // size check against the count including this sample
  assign total_inc = (total_r == '1) ? total_r : total_r + 1'b1;
  assign err = (frame_height_r == '0) || (32'(frame_height_r) > MAX_HEIGHT) ||
               (EXP_W'(total_inc) != EXP_W'(frame_height_r) * EXP_W'(IMAGE_WIDTH));

  // configuration register and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r <= CFG_W'(HEIGHT_DEFAULT);
      col_r          <= '0;
      row_r          <= '0;
      total_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_height_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_frame_end) begin
          col_r   <= '0;
          row_r   <= '0;
          total_r <= '0;
        end else begin
          total_r <= total_inc;
          if (col_r == COL_W'(IMAGE_WIDTH - 1)) begin
            col_r <= '0;
            if (32'(row_r) < MAX_HEIGHT) begin
              row_r <= row_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
    end
  end

  // first stage: position and size classification
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!hold) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bits_r <= in_depth_bits;
      s1_win_r  <= win;
      s1_last_r <= in_frame_end;
      s1_err_r  <= err;
    end
  end

  // second stage: float decode, range test and conversion to mm q4
  logic              f_sign;
  logic [7:0]        f_expo;
  logic [23:0]       f_mant;
  logic [7:0]        f_sh;
  logic [33:0]       f_mant10;
  logic [33:0]       f_low;
  logic [33:0]       f_high;
  logic [38:0]       f_scaled;
  logic              f_keep;

  assign f_sign   = s1_bits_r[31];
  assign f_expo   = s1_bits_r[30:23];
  assign f_mant   = {1'b1, s1_bits_r[22:0]};
  assign f_sh     = 8'(EXPO_REF) - f_expo;
  assign f_mant10 = 34'(f_mant) * 34'(10);
  assign f_low    = 34'(1) << f_sh;
  assign f_high   = 34'(5) << f_sh;
  assign f_scaled = 39'(f_mant) * 39'(MM_Q4) + (39'(1) << (f_sh - 8'd1));
  assign f_keep   = s1_win_r && !f_sign &&
                    (f_expo >= 8'(EXPO_LO)) && (f_expo <= 8'(EXPO_HI)) &&
                    (f_mant10 > f_low) && (34'(f_mant) < f_high);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!hold) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s2_keep_r <= f_keep;
      s2_q4_r   <= MEAN_W'(f_scaled >> f_sh);
      s2_last_r <= s1_last_r;
      s2_err_r  <= s1_err_r;
    end
  end

  // third stage: saturating sum and count, frame record on the last sample
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_nxt;
  logic [KEPT_W-1:0] cnt_nxt;

  assign sum_add = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(s2_q4_r);
  assign sum_nxt = !s2_keep_r ? sum_r : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
  assign cnt_nxt = (!s2_keep_r || cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  assign push           = s2_valid_r && s2_last_r && !q_full;
  assign push_rec.sum   = sum_nxt;
  assign push_rec.count = cnt_nxt;
  assign push_rec.err   = s2_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (s2_valid_r && !hold) begin
      if (s2_last_r) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/rmde_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "roi_mean_depth_estimator_macros.svh"
module rmde_back import rmde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rmde_rec_t         q_rec,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MEAN_W-1:0] out_mean_depth_q4,
  output logic [KEPT_W-1:0] out_kept_pixels,
  output logic              out_size_error
);

  localparam int DIVD_W = SUM_W + 1;
  localparam int STEP_W = $clog2(MEAN_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [DIVD_W-1:0]  rem_r;
  logic [DIVD_W-1:0]  dsr_r;
  logic [MEAN_W-1:0]  quo_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;
  logic [MEAN_W-1:0]  mean_r;
  logic [KEPT_W-1:0]  kept_r;
  logic               err_r;

  logic [DIVD_W-1:0]  dividend;
  logic               ovf;
  logic               bit_set;
  logic [MEAN_W-1:0]  quo_nxt;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // rounded dividend and quotient range check
  assign dividend = DIVD_W'(q_rec.sum) + DIVD_W'(q_rec.count >> 1);
  assign ovf      = dividend >= (DIVD_W'(q_rec.count) << MEAN_W);

  // one quotient bit per cycle
  assign bit_set = rem_r >= dsr_r;
  assign quo_nxt = {quo_r[MEAN_W-2:0], bit_set};

  assign out_valid         = out_valid_r;
  assign out_mean_depth_q4 = mean_r;
  assign out_kept_pixels   = kept_r;
  assign out_size_error    = err_r;

  // divider sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            kept_r <= q_rec.count;
            err_r  <= q_rec.err;
            if (q_rec.err || q_rec.count == '0) begin
              mean_r      <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (ovf) begin
              mean_r      <= '1;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              rem_r   <= dividend;
              dsr_r   <= DIVD_W'(q_rec.count) << (MEAN_W - 1);
              quo_r   <= '0;
              step_r  <= STEP_W'(MEAN_W - 1);
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (bit_set) begin
            rem_r <= rem_r - dsr_r;
          end
          dsr_r  <= dsr_r >> 1;
          quo_r  <= quo_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            mean_r      <= quo_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  `RMDE_ASSERT_IMPL(a_pop_idle, q_pop, state_r == S_IDLE, "queue popped while busy")
  `RMDE_ASSERT_IMPL(a_div_no_out, state_r == S_DIV, !out_valid_r,
                    "result shown during division")
  `RMDE_ASSERT_IMPL(a_err_zero_mean, out_valid_r && err_r, mean_r == '0,
                    "mean not zero on a size error")
  `RMDE_ASSERT_NEXT(a_div_progress, state_r == S_DIV,
                    state_r == S_DIV || state_r == S_OUT, "division left early")

endmodule
`default_nettype wire

### rtl/core/roi_mean_depth_estimator.sv
// Mean depth over the central window of a raster depth frame.
// Input channel: in_valid / in_stall with in_depth_bits (float32 metres) and
// in_frame_end on the last sample of a frame; one sample per clock while in_stall is low.
// Result channel: out_valid / out_stall with out_mean_depth_q4 (mm, 4 fraction
// bits), out_kept_pixels and out_size_error; one transaction per frame end.
// Configuration: cfg_wr_en / cfg_wr_data write the frame height; write it only
// while no frame is in flight.
// Path: a frame end sample passes the first and second front stages before it is
// pushed into the frame queue; the back end then pops it and runs its bit-serial
// divider (one quotient bit per cycle) before out_valid.
// Frames with no kept pixel, a size error or an out-of-range mean skip the
// divider. The divider runs under the next frame's accumulation; the frame
// queue holds two finished frames.
// Reset: rst_n (synchronous, active low) sets the height to 1200 and clears
// counters, accumulators, the queue and the output valid flag.
// Stall: a stalled result holds its payload; once the queue is full and a
// further frame end arrives, in_stall rises until space frees up.
`timescale 1ns / 1ps
`default_nettype none
module roi_mean_depth_estimator import rmde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DEPTH_W-1:0] in_depth_bits,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MEAN_W-1:0]  out_mean_depth_q4,
  output logic [KEPT_W-1:0]  out_kept_pixels,
  output logic               out_size_error
);

  logic      push;
  rmde_rec_t push_rec;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  rmde_rec_t q_rec;

  // pixel classification and accumulation
  rmde_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_depth_bits (in_depth_bits),
    .in_frame_end  (in_frame_end),
    .push          (push),
    .push_rec      (push_rec),
    .q_full        (q_full)
  );

  // finished frames waiting for the divider
  rmde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_rec   (q_rec)
  );

  // mean division and result register
  rmde_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rec             (q_rec),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_depth_q4 (out_mean_depth_q4),
    .out_kept_pixels   (out_kept_pixels),
    .out_size_error    (out_size_error)
  );

endmodule
`default_nettype wire

### bench/roi_mean_depth_estimator_tb.sv
`timescale 1ns / 1ps
module roi_mean_depth_estimator_tb;
  import rmde_pkg::*;

  // window columns and float decode limits, kept apart from the block's own
  localparam int unsigned ROI_COL_LO = IMAGE_WIDTH * 3 / 10;
  localparam int unsigned ROI_COL_HI = IMAGE_WIDTH * 7 / 10;
  localparam int unsigned EXPO_MIN = 120;
  localparam int unsigned EXPO_MAX = 129;
  localparam int unsigned EXPO_BIAS_Q = 150;
  localparam longint unsigned Q4_PER_METRE = 16000;
  localparam longint unsigned DEPTH_SUM_MAX = (64'd1 << SUM_W) - 1;
  localparam longint unsigned KEPT_MAX = (64'd1 << KEPT_W) - 1;
  localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 1;
  localparam longint unsigned MEAN_MAX = (64'd1 << MEAN_W) - 1;

  // depth patterns at the edges of the kept range
  localparam logic [DEPTH_W-1:0] DEPTH_JUST_UNDER_5M = 32'h409F_FFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_JUST_OVER_0M1 = 32'h3DCC_CCCD;
  localparam int unsigned EDGE_COUNT = 19;

  // run shape
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_STRETCH = 400;
  localparam int unsigned PRESSURE_PHASE = 2;
  localparam int unsigned EDGE_FRAME_LEN = ROI_COL_LO + 64;
  localparam int unsigned ITEM_BUDGET = 1250;
  localparam longint unsigned RUN_LIMIT_NS = 1_500_000;

  typedef enum int {FILL_RANDOM, FILL_EDGE_CASES} fill_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] bits;
    logic               is_last;
  } sample_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [KEPT_W-1:0] kept;
    logic              err;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DEPTH_W-1:0] in_depth_bits = '0;
  logic               in_frame_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [MEAN_W-1:0]  out_mean_depth_q4;
  logic [KEPT_W-1:0]  out_kept_pixels;
  logic               out_size_error;

  roi_mean_depth_estimator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_depth_bits     (in_depth_bits),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_depth_q4 (out_mean_depth_q4),
    .out_kept_pixels   (out_kept_pixels),
    .out_size_error    (out_size_error)
  );

  always #6 clk = ~clk;

  // predicted frame state
  logic [CFG_W-1:0] height_setting = CFG_W'(HEIGHT_DEFAULT);
  int unsigned      roi_col = 0;
  int unsigned      roi_row = 0;
  longint unsigned  samples_in_frame = 0;
  longint unsigned  depth_sum_q4 = 0;
  longint unsigned  kept_in_frame = 0;

  // transaction stores and counters
  sample_t       samples_to_send[$];
  frame_result_t results_due[$];
  int unsigned   items_queued = 0;
  int unsigned   items_accepted = 0;
  int unsigned   frames_queued = 0;
  int unsigned   frames_checked = 0;
  int unsigned   error_frames = 0;
  int unsigned   meaned_frames = 0;
  int unsigned   input_stall_cycles = 0;
  int unsigned   settings_written = 0;
  int unsigned   mismatch_count = 0;

  // idling control
  bit          gap_mode = 1'b0;
  bit          stall_mode = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cycles = 0;

  function automatic logic [DEPTH_W-1:0] edge_depth(input int unsigned k);
    case (k)
      0:       return 32'h0000_0000;   // +0
      1:       return 32'h8000_0000;   // -0
      2:       return 32'h7FC0_0000;   // quiet nan
      3:       return 32'hFFC0_0001;   // negative nan
      4:       return 32'h7F80_0000;   // +inf
      5:       return 32'hFF80_0000;   // -inf
      6:       return 32'h0000_0001;   // smallest subnormal
      7:       return 32'h007F_FFFF;   // largest subnormal
      8:       return DEPTH_JUST_OVER_0M1;
      9:       return 32'h3DCC_CCCC;   // just under 100 mm
      10:      return 32'h3DCC_CCCE;
      11:      return 32'h40A0_0000;   // exactly 5 m
      12:      return DEPTH_JUST_UNDER_5M;
      13:      return 32'h40A0_0001;
      14:      return 32'h3F80_0000;   // 1 m
      15:      return 32'hBF80_0000;   // -1 m
      16:      return 32'h3C00_0000;   // lowest exponent looked at
      17:      return 32'h4480_0000;   // far too deep
      default: return 32'h7F7F_FFFF;  // largest finite
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] random_depth();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return {1'b0, 8'($urandom_range(121, 130)), 23'($urandom)};
    if (r < 80) return DEPTH_W'($urandom);
    return edge_depth($urandom_range(0, EDGE_COUNT - 1));
  endfunction

  function automatic bit in_roi(input int unsigned col, input int unsigned row,
                                input logic [CFG_W-1:0] h);
    int unsigned hc;
    hc = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    return col >= ROI_COL_LO && col < ROI_COL_HI &&
           row >= hc * 3 / 10 && row < hc * 7 / 10;
  endfunction

  // float metres to q4 millimetres; 0 when the sample is not kept
  function automatic bit depth_to_q4(input logic [DEPTH_W-1:0] bits,
                                     output longint unsigned q4);
    int unsigned     expo;
    int unsigned     sh;
    longint unsigned mant;
    q4 = 0;
    expo = bits[30:23];
    if (bits[31] || expo < EXPO_MIN || expo > EXPO_MAX) return 1'b0;
    mant = {41'd1, bits[22:0]};
    sh = EXPO_BIAS_Q - expo;
    if (mant * 10 <= (64'd1 << sh)) return 1'b0;
    if (mant >= (64'd5 << sh)) return 1'b0;
    q4 = (mant * Q4_PER_METRE + (64'd1 << (sh - 1))) >> sh;
    return 1'b1;
  endfunction

  // advance the predicted frame by one accepted sample
  task automatic take_sample(input logic [DEPTH_W-1:0] bits, input logic is_last);
    longint unsigned q4;
    longint unsigned mean;
    bit              kept;
    frame_result_t   res;
    kept = depth_to_q4(bits, q4);
    if (in_roi(roi_col, roi_row, height_setting) && kept) begin
      depth_sum_q4 = depth_sum_q4 + q4;
      if (depth_sum_q4 > DEPTH_SUM_MAX) depth_sum_q4 = DEPTH_SUM_MAX;
      if (kept_in_frame < KEPT_MAX) kept_in_frame++;
    end
    if (samples_in_frame < TOTAL_MAX) samples_in_frame++;
    roi_col++;
    if (roi_col >= IMAGE_WIDTH) begin
      roi_col = 0;
      if (roi_row < MAX_HEIGHT) roi_row++;
    end
    if (is_last) begin
      res.err = height_setting == 0 || height_setting > MAX_HEIGHT ||
                samples_in_frame != longint'(IMAGE_WIDTH) * height_setting;
      mean = 0;
      if (!res.err && kept_in_frame != 0)
        mean = (depth_sum_q4 + kept_in_frame / 2) / kept_in_frame;
      if (mean > MEAN_MAX) mean = MEAN_MAX;
      res.mean = MEAN_W'(mean);
      res.kept = KEPT_W'(kept_in_frame);
      results_due = {results_due, res};
      roi_col = 0;
      roi_row = 0;
      samples_in_frame = 0;
      depth_sum_q4 = 0;
      kept_in_frame = 0;
    end
  endtask

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (!gap_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 16);
  endfunction

  // driver: one sample per transaction from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        take_sample(in_depth_bits, in_frame_end);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (samples_to_send.size() != 0) begin
          in_depth_bits <= samples_to_send[0].bits;
          in_frame_end <= samples_to_send[0].is_last;
          samples_to_send.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result with no frame pending: mean %0d kept %0d size_error %0b",
                 out_mean_depth_q4, out_kept_pixels, out_size_error);
          mismatch_count++;
        end else begin
          if (out_mean_depth_q4 !== results_due[0].mean) begin
            $error("mean_depth_q4: expected %0d, got %0d",
                   results_due[0].mean, out_mean_depth_q4);
            mismatch_count++;
          end
          if (out_kept_pixels !== results_due[0].kept) begin
            $error("kept_pixels: expected %0d, got %0d",
                   results_due[0].kept, out_kept_pixels);
            mismatch_count++;
          end
          if (out_size_error !== results_due[0].err) begin
            $error("size_error: expected %0b, got %0b",
                   results_due[0].err, out_size_error);
            mismatch_count++;
          end
          if (results_due[0].err) error_frames++;
          if (results_due[0].mean != 0) meaned_frames++;
          frames_checked++;
          results_due.pop_front();
        end
      end
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_mode && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_frame(input int unsigned n, input fill_t fill);
    int unsigned i;
    int unsigned col;
    int unsigned row;
    sample_t     s;
    for (i = 0; i < n; i++) begin
      col = i % IMAGE_WIDTH;
      row = i / IMAGE_WIDTH;
      s.bits = random_depth();
      if (in_roi(col, row, height_setting)) begin
        case (fill)
          FILL_EDGE_CASES: if (col - ROI_COL_LO < EDGE_COUNT) s.bits = edge_depth(col - ROI_COL_LO);
          default: ;
        endcase
      end
      s.is_last = (i == n - 1);
      samples_to_send = {samples_to_send, s};
      items_queued++;
    end
    frames_queued++;
  endtask

  // let every transaction come back, then allow the pipeline to settle
  task automatic wait_for_drain();
    while (items_accepted != items_queued || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic new_phase(input logic [CFG_W-1:0] h, input bit gaps, input bit stalls);
    wait_for_drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    height_setting = h;
    settings_written++;
    gap_mode = gaps;
    stall_mode = stalls;
  endtask

  initial begin
    int unsigned      r;
    int unsigned      n;
    int unsigned      phase_no;
    logic [CFG_W-1:0] h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames: edge values across the first window columns, odd heights
    new_phase(CFG_W'(2), 1'b0, 1'b0);
    queue_frame(EDGE_FRAME_LEN, FILL_EDGE_CASES);
    queue_frame(1, FILL_RANDOM);
    new_phase(CFG_W'(1), 1'b1, 1'b1);
    queue_frame(6, FILL_RANDOM);
    new_phase('0, 1'b1, 1'b0);
    queue_frame(5, FILL_RANDOM);
    new_phase('1, 1'b0, 1'b1);
    queue_frame(7, FILL_RANDOM);
    new_phase(CFG_W'(MAX_HEIGHT), 1'b1, 1'b1);
    queue_frame(3, FILL_RANDOM);

    // random phases of short frames over a spread of heights
    phase_no = 0;
    while (items_queued < ITEM_BUDGET) begin
      r = $urandom_range(0, 99);
      if (r < 65) h = CFG_W'($urandom_range(2, 4));
      else if (r < 75) h = CFG_W'(1);
      else begin
        case ($urandom_range(0, 3))
          0:       h = '0;
          1:       h = CFG_W'(MAX_HEIGHT);
          2:       h = '1;
          default: h = CFG_W'($urandom_range(5, MAX_HEIGHT));
        endcase
      end
      if (phase_no == PRESSURE_PHASE) begin
        // receiver holds off while short frames pile up behind it
        new_phase(h, 1'b0, 1'b0);
        hold_cycles = HOLD_STRETCH;
        repeat (10) queue_frame($urandom_range(1, 6), FILL_RANDOM);
      end else begin
        new_phase(h, $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
        repeat ($urandom_range(1, 4)) begin
          r = $urandom_range(0, 99);
          if (r < 80) n = $urandom_range(1, 24);
          else n = $urandom_range(25, 80);
          queue_frame(n, FILL_RANDOM);
        end
      end
      phase_no++;
    end

    wait_for_drain();
    $display("run covered %0d depth samples, %0d frame results over %0d height settings",
             items_accepted, frames_checked, settings_written);
    $display("%0d frames flagged a size error, %0d gave a nonzero mean, input stalled %0d cycles",
             error_frames, meaned_frames, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("roi_mean_depth_estimator: match");
    end else begin
      $display("roi_mean_depth_estimator: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("roi_mean_depth_estimator: mismatch");
    $finish;
  end

endmodule
